[rtl/sca_pkg.sv]
// Package for the sigma-clipped window average unit.
// Holds shared constants, command/status codes and controller-datapath structs.
// No dependencies.
package sca_pkg;

  localparam int SCA_DEPTH   = 256;
  localparam int SCA_DW      = 32;
  localparam int SCA_DIGIT_W = 16;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NONE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MUL_NQ = 2'd0,
    MUL_S2 = 2'd1,
    MUL_D2 = 2'd2
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P1_RD,
    S_P1_SQ,
    S_P1_ACC,
    S_NQ_GO,
    S_NQ_RUN,
    S_S2_GO,
    S_S2_RUN,
    S_P2_RD,
    S_P2_D,
    S_P2_GO,
    S_P2_RUN,
    S_DIV_CHK,
    S_DIV_RUN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic     push;
    logic     clear;
    logic     acc_init;
    logic     p1_sq;
    logic     p1_acc;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     var_ld;
    logic     var_sub;
    logic     p2_d;
    logic     p2_keep;
    logic     idx_inc;
    logic     div_go;
    logic     res_ld;
    status_e  res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic idx_last;
    logic mul_busy;
    logic div_busy;
    logic kept_zero;
  } dp_stat_t;

endpackage

[rtl/sigma_clipped_window_average_unit.sv]
// Top level of the sigma-clipped window average unit.
// Depends on sca_pkg, sca_ctrl, sca_dp (which holds sca_ram).
//
// The unit keeps a ring of the DEPTH most recent signed Q23.8 samples. Item
// kind on s_axis_tuser: push (write s_axis_tdata into the ring, count
// saturates at DEPTH), query, or clear (empty the ring). Push and clear
// give no result. A query over n stored samples gives one result:
// status 1 with average 0 when the ring is empty, otherwise the mean of the
// samples lying within one population standard deviation of the mean, rounded
// toward zero, with status 0 (status 2, average 0, if no sample qualifies).
// The band test is exact: (n*x - S)^2 <= n*Q - S^2. A query runs a first pass
// over the samples (read, square, accumulate per sample), the two variance
// products n*Q and S^2, a second pass (read, form n*x - S, square it and test
// it per sample), then restoring division of the kept sum by the kept count.
// The products use a 16-bit digit-serial multiplier with NDIG =
// ceil((32+clog2(DEPTH+1)+1)/16) digits (3 at DEPTH 256), shared by the
// variance products and the second pass; the RAM has a single read port.
// Items are taken one at a time; a result waits in an output register, so
// pushes and clears keep flowing while it is not taken.
module sigma_clipped_window_average_unit #(
  parameter int DEPTH = sca_pkg::SCA_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] sample
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] average
  output logic [1:0]  m_axis_tuser   // [1:0] status
);
  import sca_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  status_e  status;
  logic signed [SCA_DW-1:0] average;

  // Sequence queries and gate the input side.
  sca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (cmd_e'(s_axis_tuser)),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  // Hold samples, sums and arithmetic units.
  sca_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  ($signed(s_axis_tdata)),
    .cmd_i     (dp_cmd),
    .stat_o    (dp_stat),
    .average_o (average),
    .status_o  (status)
  );

  assign m_axis_tdata = average;
  assign m_axis_tuser = status;
endmodule

[rtl/sca_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[rtl/sca_ctrl.sv]
// Controller state machine of the sigma-clipped window average unit.
// Depends on sca_pkg; drives the datapath through dp_cmd_t, reads dp_stat_t.
module sca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  sca_pkg::cmd_e     in_cmd_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sca_pkg::dp_cmd_t  cmd_o,
  input  sca_pkg::dp_stat_t stat_i
);
  import sca_pkg::*;

  state_e  state_q, state_d;
  status_e code_q, code_d;
  logic    out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      code_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_cmd_i)
            CMD_PUSH:  cmd_o.push = 1'b1;
            CMD_CLEAR: cmd_o.clear = 1'b1;
            CMD_QUERY: begin
              if (stat_i.fill_zero) begin
                code_d  = ST_EMPTY;
                state_d = S_DONE;
              end else begin
                cmd_o.acc_init = 1'b1;
                state_d        = S_P1_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_P1_RD:  state_d = S_P1_SQ;
      S_P1_SQ: begin
        cmd_o.p1_sq = 1'b1;
        state_d     = S_P1_ACC;
      end
      S_P1_ACC: begin
        cmd_o.p1_acc = 1'b1;
        if (stat_i.idx_last) begin
          state_d = S_NQ_GO;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_P1_RD;
        end
      end
      S_NQ_GO: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_NQ;
        state_d       = S_NQ_RUN;
      end
      S_NQ_RUN: begin
        if (!stat_i.mul_busy) begin
          cmd_o.var_ld = 1'b1;
          state_d      = S_S2_GO;
        end
      end
      S_S2_GO: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_S2;
        state_d       = S_S2_RUN;
      end
      S_S2_RUN: begin
        if (!stat_i.mul_busy) begin
          cmd_o.var_sub = 1'b1;
          state_d       = S_P2_RD;
        end
      end
      S_P2_RD: state_d = S_P2_D;
      S_P2_D: begin
        cmd_o.p2_d = 1'b1;
        state_d    = S_P2_GO;
      end
      S_P2_GO: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_D2;
        state_d       = S_P2_RUN;
      end
      S_P2_RUN: begin
        if (!stat_i.mul_busy) begin
          cmd_o.p2_keep = 1'b1;
          if (stat_i.idx_last) begin
            state_d = S_DIV_CHK;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_P2_RD;
          end
        end
      end
      S_DIV_CHK: begin
        if (stat_i.kept_zero) begin
          code_d  = ST_NONE;
          state_d = S_DONE;
        end else begin
          cmd_o.div_go = 1'b1;
          state_d      = S_DIV_RUN;
        end
      end
      S_DIV_RUN: begin
        if (!stat_i.div_busy) begin
          code_d  = ST_OK;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_ld   = 1'b1;
          cmd_o.res_code = code_q;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
endmodule

[rtl/sca_dp.sv]
// Datapath of the sigma-clipped window average unit: sample RAM, sums,
// digit-serial multiplier, restoring divider and result register.
// Depends on sca_pkg and sca_ram.
module sca_dp #(
  parameter int DEPTH = sca_pkg::SCA_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic signed [sca_pkg::SCA_DW-1:0] sample_i,
  input  sca_pkg::dp_cmd_t               cmd_i,
  output sca_pkg::dp_stat_t              stat_o,
  output logic signed [sca_pkg::SCA_DW-1:0] average_o,
  output sca_pkg::status_e               status_o
);
  import sca_pkg::*;

  localparam int DW   = SCA_DW;
  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = DW + CW;
  localparam int QW   = 2 * DW + CW;
  localparam int MA   = QW;
  localparam int MB   = SW + 1;
  localparam int PW   = MA + MB;
  localparam int GW   = SCA_DIGIT_W;
  localparam int NDIG = (MB + GW - 1) / GW;
  localparam int BPW  = NDIG * GW;
  localparam int MCW  = $clog2(NDIG + 1);
  localparam int DCW  = $clog2(SW + 1);

  // control-side state
  logic [AW-1:0]  wp_q, idx_q;
  logic [CW-1:0]  fill_q, kept_q;
  logic           mbusy_q, dbusy_q;
  logic [MCW-1:0] mcnt_q;
  logic [DCW-1:0] dcnt_q;
  // payload
  logic signed [SW-1:0] sum_q, ksum_q;
  logic [2*DW-1:0]      sq_q;
  logic [QW-1:0]        q_q;
  logic [PW-1:0]        var_q, macc_q;
  logic signed [DW-1:0] x_q;
  logic signed [MB-1:0] d_q;
  logic [MA-1:0]        ma_q;
  logic [BPW-1:0]       mb_q;
  logic [SW-1:0]        dnum_q;
  logic [CW-1:0]        drem_q;
  logic signed [DW-1:0] avg_q;
  status_e              stat_q;

  logic [DW-1:0]        rd_data;
  logic signed [DW-1:0] x_rd;
  logic signed [2*DW-1:0] sq_full;
  logic [SW-1:0]        abs_s;
  logic [MB-1:0]        abs_d;
  logic signed [MB-1:0] nx, d_new;
  logic [GW-1:0]        digit;
  logic [MA+GW-1:0]     pp;
  logic [PW-1:0]        pp_sh;
  logic [CW:0]          rem2;
  logic                 ge;
  logic [DW-1:0]        qmag;

  sca_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  assign x_rd    = $signed(rd_data);
  assign sq_full = x_rd * x_rd;
  assign abs_s   = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign nx      = $signed({1'b0, fill_q}) * MB'(x_rd);
  assign d_new   = nx - MB'(sum_q);
  assign abs_d   = d_q[MB-1] ? MB'(-d_q) : MB'(d_q);
  assign digit   = mb_q[mcnt_q * GW +: GW];
  assign pp      = (MA + GW)'(ma_q) * (MA + GW)'(digit);
  assign pp_sh   = PW'(pp) << (GW * mcnt_q);
  assign rem2    = {drem_q, dnum_q[SW-1]};
  assign ge      = rem2 >= {1'b0, kept_q};
  assign qmag    = dnum_q[DW-1:0];

  // state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      fill_q  <= '0;
      idx_q   <= '0;
      kept_q  <= '0;
      mbusy_q <= 1'b0;
      mcnt_q  <= '0;
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
      stat_q  <= ST_OK;
    end else begin
      if (cmd_i.push) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
        if (fill_q != CW'(DEPTH)) begin
          fill_q <= fill_q + CW'(1);
        end
      end
      if (cmd_i.clear) begin
        wp_q   <= '0;
        fill_q <= '0;
      end
      if (cmd_i.acc_init || cmd_i.var_sub) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.var_sub) begin
        kept_q <= '0;
      end else if (cmd_i.p2_keep && macc_q <= var_q) begin
        kept_q <= kept_q + CW'(1);
      end
      if (cmd_i.mul_go) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= '0;
      end else if (mbusy_q) begin
        mcnt_q <= mcnt_q + MCW'(1);
        if (mcnt_q == MCW'(NDIG - 1)) begin
          mbusy_q <= 1'b0;
        end
      end
      if (cmd_i.div_go) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= '0;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(SW - 1)) begin
          dbusy_q <= 1'b0;
        end
      end
      if (cmd_i.res_ld) begin
        stat_q <= cmd_i.res_code;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_init) begin
      sum_q <= '0;
      q_q   <= '0;
    end
    if (cmd_i.p1_sq) begin
      sq_q  <= $unsigned(sq_full);
      sum_q <= sum_q + SW'(x_rd);
    end
    if (cmd_i.p1_acc) begin
      q_q <= q_q + QW'(sq_q);
    end
    if (cmd_i.mul_go) begin
      macc_q <= '0;
      case (cmd_i.mul_sel)
        MUL_NQ: begin
          ma_q <= q_q;
          mb_q <= BPW'(fill_q);
        end
        MUL_S2: begin
          ma_q <= MA'(abs_s);
          mb_q <= BPW'(abs_s);
        end
        MUL_D2: begin
          ma_q <= MA'(abs_d);
          mb_q <= BPW'(abs_d);
        end
        default: begin
          ma_q <= '0;
          mb_q <= '0;
        end
      endcase
    end else if (mbusy_q) begin
      macc_q <= macc_q + pp_sh;
    end
    if (cmd_i.var_ld) begin
      var_q <= macc_q;
    end
    if (cmd_i.var_sub) begin
      var_q  <= var_q - macc_q;
      ksum_q <= '0;
    end
    if (cmd_i.p2_d) begin
      x_q <= x_rd;
      d_q <= d_new;
    end
    if (cmd_i.p2_keep && macc_q <= var_q) begin
      ksum_q <= ksum_q + SW'(x_q);
    end
    if (cmd_i.div_go) begin
      dnum_q <= ksum_q[SW-1] ? SW'(-ksum_q) : SW'(ksum_q);
      drem_q <= '0;
    end else if (dbusy_q) begin
      drem_q <= ge ? CW'(rem2 - {1'b0, kept_q}) : CW'(rem2);
      dnum_q <= {dnum_q[SW-2:0], ge};
    end
    if (cmd_i.res_ld) begin
      if (cmd_i.res_code == ST_OK) begin
        avg_q <= ksum_q[SW-1] ? $signed(-qmag) : $signed(qmag);
      end else begin
        avg_q <= '0;
      end
    end
  end

  assign stat_o.fill_zero = (fill_q == '0);
  assign stat_o.idx_last  = (CW'(idx_q) == fill_q - CW'(1));
  assign stat_o.mul_busy  = mbusy_q;
  assign stat_o.div_busy  = dbusy_q;
  assign stat_o.kept_zero = (kept_q == '0);
  assign average_o        = avg_q;
  assign status_o         = stat_q;
endmodule

[rtl/sca_checker.sv]
// Port-level checker for the sigma-clipped window average unit, with its bind.
// Depends on sca_pkg.
module sca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import sca_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("nonzero average on error status");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_QUERY) |=> !s_axis_tready)
    else $error("input taken while a query is in progress");
endmodule

bind sigma_clipped_window_average_unit sca_checker u_sca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
